// ----- rtl/bdp_pkg.sv -----
package bdp_pkg;

    // stream field widths
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 48;
    localparam int OUT_ADDR_W   = 32;

    // command codes on the input tuser
    localparam logic [1:0] CMD_PATCH = 2'd0;
    localparam logic [1:0] CMD_BASE  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // result kinds on the output tuser
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_REQ  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_HEADER = 3'd1;
    localparam logic [2:0] ERR_SHORT  = 3'd2;
    localparam logic [2:0] ERR_SEEK   = 3'd3;
    localparam logic [2:0] ERR_VARINT = 3'd4;
    localparam logic [2:0] ERR_ORDER  = 3'd5;

    // patch format constants
    localparam logic [31:0] HDR_MAGIC        = 32'h0000_B1DF;
    localparam logic [31:0] HDR_VERSION      = 32'h0000_1000;
    localparam logic [3:0]  HDR_BYTES        = 4'd8;
    localparam logic [3:0]  VARINT_MAX_BYTES = 4'd10;
    localparam logic [7:0]  VARINT_DATA      = 8'h7F;
    localparam logic [7:0]  VARINT_CONT      = 8'h80;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] patch_byte;
        logic [7:0] base_byte;
        logic       base_valid;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            out_byte;
        logic [OUT_ADDR_W-1:0] base_address;
        logic                  status_ok;
        logic [2:0]            err_code;
    } result_t;

    // expected header byte, little-endian magic then version
    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [31:0] word;
        logic [31:0] shifted;
        word    = idx[2] ? HDR_VERSION : HDR_MAGIC;
        shifted = word >> {idx[1:0], 3'b000};
        return shifted[7:0];
    endfunction

endpackage

// ----- rtl/bdp_core.sv -----
module bdp_core #(
    parameter int ADDR_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  bdp_pkg::in_item_t  item,
    output logic               res_valid,
    output bdp_pkg::result_t   res
);

    typedef enum logic [1:0] {PH_HEADER, PH_VARINT, PH_ADD, PH_COPY} phase_t;
    typedef enum logic [1:0] {TG_ADDLEN, TG_COPYLEN, TG_SEEK} target_t;

    phase_t               phase_reg, phase_next;
    target_t              target_reg, target_next;
    logic [3:0]           hdr_count_reg, hdr_count_next;
    logic                 hdr_match_reg, hdr_match_next;
    logic [63:0]          vint_value_reg, vint_value_next;
    logic [3:0]           vint_bytes_reg, vint_bytes_next;
    logic [63:0]          bytes_left_reg, bytes_left_next;
    logic [ADDR_BITS-1:0] base_pos_reg, base_pos_next;
    logic [7:0]           held_diff_reg, held_diff_next;
    logic                 awaiting_reg, awaiting_next;
    logic                 error_reg, error_next;

    // header byte compare
    logic       hdr_match_upd;
    logic [3:0] hdr_count_inc;
    assign hdr_match_upd = hdr_match_reg &&
                           (item.patch_byte == bdp_pkg::header_byte(hdr_count_reg[2:0]));
    assign hdr_count_inc = hdr_count_reg + 4'd1;

    // varint accumulate
    logic [6:0]  vint_shamt;
    logic [63:0] vint_acc;
    logic        vint_last;
    assign vint_shamt = 7'(vint_bytes_reg) * 7'd7;
    assign vint_acc   = vint_value_reg |
                        ({56'b0, item.patch_byte & bdp_pkg::VARINT_DATA} << vint_shamt);
    assign vint_last  = (item.patch_byte & bdp_pkg::VARINT_CONT) == 8'h00;

    // zigzag seek arithmetic
    logic [63:0] seek_mag;
    logic [64:0] pos_wide;
    logic [64:0] fwd_sum;
    logic [64:0] back_diff;
    logic        fwd_bad;
    logic        back_bad;
    assign seek_mag  = vint_acc >> 1;
    assign pos_wide  = 65'(base_pos_reg);
    assign fwd_sum   = {1'b0, seek_mag} + pos_wide;
    assign fwd_bad   = (fwd_sum >> ADDR_BITS) != 65'd0;
    assign back_bad  = {1'b0, seek_mag} >= pos_wide;
    assign back_diff = pos_wide - {1'b0, seek_mag} - 65'd1;

    // low address bits for the request
    localparam int OUT_ADDR_W_L = bdp_pkg::OUT_ADDR_W;
    logic [OUT_ADDR_W_L-1:0] addr_out;
    assign addr_out = pos_wide[OUT_ADDR_W_L-1:0];

    // end status condition
    logic end_ok;
    assign end_ok = !error_reg && !awaiting_reg && (phase_reg == PH_VARINT) &&
                    (target_reg == TG_ADDLEN);

    // step logic
    always_comb
    begin
        phase_next      = phase_reg;
        target_next     = target_reg;
        hdr_count_next  = hdr_count_reg;
        hdr_match_next  = hdr_match_reg;
        vint_value_next = vint_value_reg;
        vint_bytes_next = vint_bytes_reg;
        bytes_left_next = bytes_left_reg;
        base_pos_next   = base_pos_reg;
        held_diff_next  = held_diff_reg;
        awaiting_next   = awaiting_reg;
        error_next      = error_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (step_en)
        begin
            unique case (item.command)
                bdp_pkg::CMD_END:
                begin
                    res_valid     = 1'b1;
                    res.kind      = bdp_pkg::KIND_END;
                    res.status_ok = end_ok;
                end
                bdp_pkg::CMD_PATCH:
                begin
                    if (!error_reg)
                    begin
                        if (awaiting_reg)
                        begin
                            res_valid    = 1'b1;
                            res.kind     = bdp_pkg::KIND_ERR;
                            res.err_code = bdp_pkg::ERR_ORDER;
                            error_next   = 1'b1;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_HEADER:
                                begin
                                    hdr_match_next = hdr_match_upd;
                                    hdr_count_next = hdr_count_inc;
                                    if (hdr_count_inc >= bdp_pkg::HDR_BYTES)
                                    begin
                                        if (!hdr_match_upd)
                                        begin
                                            res_valid    = 1'b1;
                                            res.kind     = bdp_pkg::KIND_ERR;
                                            res.err_code = bdp_pkg::ERR_HEADER;
                                            error_next   = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next  = PH_VARINT;
                                            target_next = TG_ADDLEN;
                                        end
                                    end
                                end
                                PH_VARINT:
                                begin
                                    if (vint_bytes_reg >= bdp_pkg::VARINT_MAX_BYTES)
                                    begin
                                        res_valid    = 1'b1;
                                        res.kind     = bdp_pkg::KIND_ERR;
                                        res.err_code = bdp_pkg::ERR_VARINT;
                                        error_next   = 1'b1;
                                    end
                                    else if (!vint_last)
                                    begin
                                        vint_value_next = vint_acc;
                                        vint_bytes_next = vint_bytes_reg + 4'd1;
                                    end
                                    else
                                    begin
                                        vint_value_next = '0;
                                        vint_bytes_next = '0;
                                        priority if (target_reg == TG_ADDLEN)
                                        begin
                                            if (vint_acc == 64'd0)
                                                target_next = TG_COPYLEN;
                                            else
                                            begin
                                                bytes_left_next = vint_acc;
                                                phase_next      = PH_ADD;
                                            end
                                        end
                                        else if (target_reg == TG_COPYLEN)
                                        begin
                                            if (vint_acc == 64'd0)
                                                target_next = TG_SEEK;
                                            else
                                            begin
                                                bytes_left_next = vint_acc;
                                                phase_next      = PH_COPY;
                                            end
                                        end
                                        else
                                        begin
                                            // zigzag: odd is negative
                                            if (vint_acc[0] ? back_bad : fwd_bad)
                                            begin
                                                res_valid    = 1'b1;
                                                res.kind     = bdp_pkg::KIND_ERR;
                                                res.err_code = bdp_pkg::ERR_SEEK;
                                                error_next   = 1'b1;
                                            end
                                            else
                                            begin
                                                base_pos_next = vint_acc[0] ?
                                                    back_diff[ADDR_BITS-1:0] :
                                                    fwd_sum[ADDR_BITS-1:0];
                                                target_next   = TG_ADDLEN;
                                            end
                                        end
                                    end
                                end
                                PH_ADD:
                                begin
                                    held_diff_next   = item.patch_byte;
                                    awaiting_next    = 1'b1;
                                    res_valid        = 1'b1;
                                    res.kind         = bdp_pkg::KIND_REQ;
                                    res.base_address = addr_out;
                                end
                                PH_COPY:
                                begin
                                    res_valid       = 1'b1;
                                    res.kind        = bdp_pkg::KIND_BYTE;
                                    res.out_byte    = item.patch_byte;
                                    bytes_left_next = bytes_left_reg - 64'd1;
                                    if (bytes_left_reg == 64'd1)
                                    begin
                                        phase_next  = PH_VARINT;
                                        target_next = TG_SEEK;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                bdp_pkg::CMD_BASE:
                begin
                    if (!error_reg)
                    begin
                        if (!awaiting_reg)
                        begin
                            res_valid    = 1'b1;
                            res.kind     = bdp_pkg::KIND_ERR;
                            res.err_code = bdp_pkg::ERR_ORDER;
                            error_next   = 1'b1;
                        end
                        else if (!item.base_valid)
                        begin
                            awaiting_next = 1'b0;
                            res_valid     = 1'b1;
                            res.kind      = bdp_pkg::KIND_ERR;
                            res.err_code  = bdp_pkg::ERR_SHORT;
                            error_next    = 1'b1;
                        end
                        else
                        begin
                            awaiting_next   = 1'b0;
                            res_valid       = 1'b1;
                            res.kind        = bdp_pkg::KIND_BYTE;
                            res.out_byte    = item.base_byte + held_diff_reg;
                            base_pos_next   = base_pos_reg + ADDR_BITS'(1);
                            bytes_left_next = bytes_left_reg - 64'd1;
                            if (bytes_left_reg == 64'd1)
                            begin
                                phase_next  = PH_VARINT;
                                target_next = TG_COPYLEN;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            target_reg     <= TG_ADDLEN;
            hdr_count_reg  <= '0;
            hdr_match_reg  <= 1'b1;
            vint_value_reg <= '0;
            vint_bytes_reg <= '0;
            bytes_left_reg <= '0;
            base_pos_reg   <= '0;
            held_diff_reg  <= '0;
            awaiting_reg   <= 1'b0;
            error_reg      <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            target_reg     <= target_next;
            hdr_count_reg  <= hdr_count_next;
            hdr_match_reg  <= hdr_match_next;
            vint_value_reg <= vint_value_next;
            vint_bytes_reg <= vint_bytes_next;
            bytes_left_reg <= bytes_left_next;
            base_pos_reg   <= base_pos_next;
            held_diff_reg  <= held_diff_next;
            awaiting_reg   <= awaiting_next;
            error_reg      <= error_next;
        end
    end

    // errors are sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("error flag cleared");

    // a pending base response only exists in the add phase
    a_await_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (phase_reg == PH_ADD))
        else $error("base response pending outside add phase");

    // after an error only end status comes out
    a_no_data_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res_valid && error_reg) |-> (res.kind == bdp_pkg::KIND_END))
        else $error("data result after sticky error");

endmodule

// ----- rtl/binary_delta_patch_applier.sv -----
// Binary delta patch applier: takes one item per clock cycle on the input stream, whether a
// patch byte, a base byte response or an end command, and gives at most one result item per
// input item. Each item is captured in an input register and worked by combinational step
// logic into the result register, and the sustained rate is one item per cycle while the
// output side takes results; a stalled output holds the input item and drops s_axis_tready
// in the same cycle. The step logic (header check, LEB128 accumulate, zigzag seek add and
// compare, add-byte sum) sets the clock. An add byte yields a base read request; the caller
// answers with a base response item. Errors are sticky; after one, only end commands give a
// result (status_ok low).
module binary_delta_patch_applier #(
    parameter int ADDR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // patch_byte [7:0], base_byte [15:8], base_valid [16]
    input  logic [1:0]  s_axis_tuser,   // command [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_byte [7:0], base_address [39:8],
                                        // status_ok [40], err_code [43:41]
    output logic [1:0]  m_axis_tuser    // kind [1:0]
);

    logic                in_valid_reg;
    bdp_pkg::in_item_t   in_item_reg;
    logic                out_valid_reg;
    bdp_pkg::result_t    out_res_reg;
    logic                out_free;
    logic                step_en;
    logic                res_valid;
    bdp_pkg::result_t    res;
    bdp_pkg::in_item_t   in_item;

    // flow control between the two registers
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || step_en;

    // unpack the input item
    assign in_item.command    = s_axis_tuser;
    assign in_item.patch_byte = s_axis_tdata[7:0];
    assign in_item.base_byte  = s_axis_tdata[15:8];
    assign in_item.base_valid = s_axis_tdata[16];

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= in_item;
    end

    bdp_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step_en && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res_valid)
            out_res_reg <= res;
    end

    // pack the result item
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {4'b0000, out_res_reg.err_code, out_res_reg.status_ok,
                            out_res_reg.base_address, out_res_reg.out_byte};

    // error results always carry a code
    a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == bdp_pkg::KIND_ERR)) |->
            (out_res_reg.err_code != bdp_pkg::ERR_NONE))
        else $error("error result without code");

    // non-error results carry no code
    a_ok_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != bdp_pkg::KIND_ERR)) |->
            (out_res_reg.err_code == bdp_pkg::ERR_NONE))
        else $error("error code on non-error result");

    // a held input item is not dropped while the output stalls
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input item lost under stall");

endmodule

// ----- dv/binary_delta_patch_applier_tb.sv -----
module binary_delta_patch_applier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ADDR_BITS   = 32;
    localparam logic [63:0] POS_MAX     = (64'd1 << ADDR_BITS) - 64'd1;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [63:0] HDR_WORDS   = {bdp_pkg::HDR_VERSION, bdp_pkg::HDR_MAGIC};
    localparam int          ITEMS       = 2000;
    localparam int          N_ROWS      = 25;
    localparam int          HDR_ROW0    = 2;
    localparam int          DRAIN_LIMIT = 2000;

    typedef enum logic [1:0] {PH_HEADER, PH_VARINT, PH_ADD, PH_COPY} phase_t;
    typedef enum logic [1:0] {TGT_ADDLEN, TGT_COPYLEN, TGT_SEEK} target_t;
    // how a directed row is checked: by the predictor, no result, or the typed result
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RES} chk_t;
    // the one error that closes a run, since errors are sticky and reset comes once
    typedef enum logic [2:0] {
        FAULT_SEEK, FAULT_VARINT, FAULT_EARLY_PATCH, FAULT_STRAY_BASE, FAULT_SHORT, FAULT_HEADER
    } fault_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       pb;
        logic [7:0]       bb;
        logic             bv;
        chk_t             chk;
        bdp_pkg::result_t res;
    } row_t;

    localparam bdp_pkg::result_t NO_RES = '0;

    // directed rows: reset state, header, varints, add and copy at extremes, seeks, end
    localparam row_t DIRECTED [N_ROWS] = '{
        '{bdp_pkg::CMD_END, 8'h00, 8'h00, 1'b0, CHK_RES,
          '{bdp_pkg::KIND_END, 8'h00, 32'h0, 1'b0, bdp_pkg::ERR_NONE}},
        '{CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, CHK_NONE, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_MAGIC[7:0],     8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_MAGIC[15:8],    8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_MAGIC[23:16],   8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_MAGIC[31:24],   8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_VERSION[7:0],   8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_VERSION[15:8],  8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_VERSION[23:16], 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, bdp_pkg::HDR_VERSION[31:24], 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_END, 8'h00, 8'h00, 1'b0, CHK_RES,
          '{bdp_pkg::KIND_END, 8'h00, 32'h0, 1'b1, bdp_pkg::ERR_NONE}},
        '{bdp_pkg::CMD_PATCH, 8'h82, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'h00, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'hFF, 8'h00, 1'b1, CHK_RES,
          '{bdp_pkg::KIND_REQ, 8'h00, 32'h0, 1'b0, bdp_pkg::ERR_NONE}},
        '{bdp_pkg::CMD_BASE,  8'h00, 8'hFF, 1'b1, CHK_RES,
          '{bdp_pkg::KIND_BYTE, 8'hFE, 32'h0, 1'b0, bdp_pkg::ERR_NONE}},
        '{bdp_pkg::CMD_PATCH, 8'h00, 8'hFF, 1'b1, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_BASE,  8'hFF, 8'h00, 1'b1, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'h01, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'hA5, 8'h5A, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'h01, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'h00, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'h00, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_PATCH, 8'h00, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{bdp_pkg::CMD_END,   8'h00, 8'h00, 1'b0, CHK_MODEL, NO_RES},
        '{CMD_UNUSED, 8'h00, 8'h00, 1'b0, CHK_NONE, NO_RES}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // patch_byte [7:0], base_byte [15:8], base_valid [16]
    logic [1:0]  s_axis_tuser = '0;   // command [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // out_byte [7:0], base_address [39:8],
                                      // status_ok [40], err_code [43:41]
    logic [1:0]  m_axis_tuser;        // kind [1:0]

    // patch state as the predictor tracks it
    phase_t      st_phase     = PH_HEADER;
    target_t     st_target    = TGT_ADDLEN;
    logic [3:0]  hdr_count    = '0;
    logic        hdr_ok       = 1'b1;
    logic [63:0] vint_acc     = '0;
    logic [3:0]  vint_len     = '0;
    logic [63:0] run_left     = '0;
    logic [63:0] base_pos     = '0;
    logic [7:0]  diff_hold    = '0;
    logic        base_pending = 1'b0;
    logic        sticky_err   = 1'b0;

    bdp_pkg::result_t awaited_results [$];
    int unsigned items_in     = 0;
    int unsigned results_seen = 0;
    int unsigned fails        = 0;
    bit          calm         = 1'b0;
    fault_t      fault;

    binary_delta_patch_applier #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // sticky error result
    function automatic bit raise(input logic [2:0] code, output bdp_pkg::result_t r);
        sticky_err = 1'b1;
        r          = '0;
        r.kind     = bdp_pkg::KIND_ERR;
        r.err_code = code;
        return 1'b1;
    endfunction

    // advance the patch state by one accepted item, return 1 when it gives a result
    function automatic bit patch_step(input bdp_pkg::in_item_t it,
                                      output bdp_pkg::result_t r);
        logic [63:0] acc;
        logic [63:0] mag;
        r = '0;
        if (it.command == bdp_pkg::CMD_END)
        begin
            r.kind      = bdp_pkg::KIND_END;
            r.status_ok = !sticky_err && !base_pending && st_phase == PH_VARINT
                          && st_target == TGT_ADDLEN;
            return 1'b1;
        end
        if (it.command == CMD_UNUSED || sticky_err)
            return 1'b0;

        // base byte response closes one add byte
        if (it.command == bdp_pkg::CMD_BASE)
        begin
            if (!base_pending)
                return raise(bdp_pkg::ERR_ORDER, r);
            base_pending = 1'b0;
            if (!it.base_valid)
                return raise(bdp_pkg::ERR_SHORT, r);
            r.kind     = bdp_pkg::KIND_BYTE;
            r.out_byte = it.base_byte + diff_hold;
            base_pos   = (base_pos + 64'd1) & POS_MAX;
            run_left   = run_left - 64'd1;
            if (run_left == 0)
            begin
                st_phase  = PH_VARINT;
                st_target = TGT_COPYLEN;
            end
            return 1'b1;
        end

        if (base_pending)
            return raise(bdp_pkg::ERR_ORDER, r);
        case (st_phase)
            // header bytes compared one by one, verdict after the last
            PH_HEADER:
            begin
                if (it.patch_byte != HDR_WORDS[8 * hdr_count[2:0] +: 8])
                    hdr_ok = 1'b0;
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= bdp_pkg::HDR_BYTES)
                begin
                    if (!hdr_ok)
                        return raise(bdp_pkg::ERR_HEADER, r);
                    st_phase  = PH_VARINT;
                    st_target = TGT_ADDLEN;
                end
                return 1'b0;
            end
            // leb128 accumulate, bits past 63 fall off
            PH_VARINT:
            begin
                if (vint_len >= bdp_pkg::VARINT_MAX_BYTES)
                    return raise(bdp_pkg::ERR_VARINT, r);
                vint_acc = vint_acc | ({56'd0, it.patch_byte & bdp_pkg::VARINT_DATA}
                                       << (7 * vint_len));
                vint_len = vint_len + 4'd1;
                if ((it.patch_byte & bdp_pkg::VARINT_CONT) != 0)
                    return 1'b0;
                acc      = vint_acc;
                vint_acc = '0;
                vint_len = '0;
                case (st_target)
                    TGT_ADDLEN:
                    begin
                        if (acc == 0)
                            st_target = TGT_COPYLEN;
                        else
                        begin
                            run_left = acc;
                            st_phase = PH_ADD;
                        end
                    end
                    TGT_COPYLEN:
                    begin
                        if (acc == 0)
                            st_target = TGT_SEEK;
                        else
                        begin
                            run_left = acc;
                            st_phase = PH_COPY;
                        end
                    end
                    default:
                    begin
                        // zigzag seek, odd values move backward by mag + 1
                        mag = acc >> 1;
                        if (acc[0])
                        begin
                            if (mag >= base_pos)
                                return raise(bdp_pkg::ERR_SEEK, r);
                            base_pos = base_pos - mag - 64'd1;
                        end
                        else
                        begin
                            if (mag > POS_MAX - base_pos)
                                return raise(bdp_pkg::ERR_SEEK, r);
                            base_pos = base_pos + mag;
                        end
                        st_target = TGT_ADDLEN;
                    end
                endcase
                return 1'b0;
            end
            PH_ADD:
            begin
                diff_hold      = it.patch_byte;
                base_pending   = 1'b1;
                r.kind         = bdp_pkg::KIND_REQ;
                r.base_address = base_pos[bdp_pkg::OUT_ADDR_W-1:0];
                return 1'b1;
            end
            default:
            begin
                r.kind     = bdp_pkg::KIND_BYTE;
                r.out_byte = it.patch_byte;
                run_left   = run_left - 64'd1;
                if (run_left == 0)
                begin
                    st_phase  = PH_VARINT;
                    st_target = TGT_SEEK;
                end
                return 1'b1;
            end
        endcase
    endfunction

    // present one item after a random gap, wait for acceptance, record what it should give
    task automatic drive(input logic [1:0] cmd, input logic [7:0] pb, input logic [7:0] bb,
                         input logic bv, input chk_t chk = CHK_MODEL,
                         input bdp_pkg::result_t fixed = NO_RES);
        bdp_pkg::in_item_t it;
        bdp_pkg::result_t  r;
        bit                has;
        int unsigned       gap;
        it.command    = cmd;
        it.patch_byte = pb;
        it.base_byte  = bb;
        it.base_valid = bv;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, bv, bb, pb};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        has = patch_step(it, r);
        if (chk == CHK_NONE)
            has = 1'b0;
        else if (chk == CHK_RES)
        begin
            has = 1'b1;
            r   = fixed;
        end
        if (has)
            awaited_results.push_back(r);
        if (cmd != CMD_UNUSED)
            items_in++;
    endtask

    // any command with any content
    task automatic drive_noise();
        drive(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
    endtask

    // now and then an end query or an unused command mid stream
    task automatic maybe_interject();
        if ($urandom_range(0, 19) == 0)
            drive($urandom_range(0, 1) ? bdp_pkg::CMD_END : CMD_UNUSED,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    // leb128 encode, optionally padded out to the longest legal length
    task automatic send_varint(input logic [63:0] v, input bit pad);
        logic [7:0]  b;
        int unsigned n;
        bit          last;
        n = 0;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            n++;
            last = (v == 0) && !(pad && n < bdp_pkg::VARINT_MAX_BYTES);
            // junk in the bits above bit 63, which the block drops
            if (pad && n == bdp_pkg::VARINT_MAX_BYTES)
                b = 8'($urandom_range(0, 255)) & 8'h7E;
            if (!last)
                b = b | bdp_pkg::VARINT_CONT;
            maybe_interject();
            drive(bdp_pkg::CMD_PATCH, b, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        end
        while (!last);
    endtask

    // one well-formed add / copy / seek record with random content
    task automatic send_record();
        int unsigned n_add;
        int unsigned n_copy;
        int unsigned k;
        logic [63:0] t;
        logic [63:0] d;
        n_add  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        n_copy = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        send_varint(64'(n_add), $urandom_range(0, 15) == 0);
        for (k = 0; k < n_add; k++)
        begin
            maybe_interject();
            drive(bdp_pkg::CMD_PATCH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
            maybe_interject();
            drive(bdp_pkg::CMD_BASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b1);
        end
        send_varint(64'(n_copy), $urandom_range(0, 15) == 0);
        for (k = 0; k < n_copy; k++)
        begin
            maybe_interject();
            drive(bdp_pkg::CMD_PATCH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        end

        // seek target: near the top so adds wrap, the two ends, anywhere, or close by
        case ($urandom_range(0, 9))
            0: t = POS_MAX - 64'($urandom_range(0, 3));
            1: t = '0;
            2: t = POS_MAX;
            3: t = {$urandom, $urandom} & POS_MAX;
            default:
            begin
                d = 64'($urandom_range(0, 40));
                if ($urandom_range(0, 1) && d <= base_pos)
                    t = base_pos - d;
                else if (d <= POS_MAX - base_pos)
                    t = base_pos + d;
                else
                    t = base_pos;
            end
        endcase
        if (t >= base_pos)
            d = (t - base_pos) << 1;
        else
            d = ((base_pos - t - 64'd1) << 1) | 64'd1;
        send_varint(d, $urandom_range(0, 15) == 0);
    endtask

    // the closing error, entered from an add-length boundary
    task automatic inject_fault();
        logic [63:0] mag;
        case (fault)
            FAULT_SEEK:
            begin
                send_varint(64'd0, 1'b0);
                send_varint(64'd0, 1'b0);
                if ($urandom_range(0, 1))
                begin
                    mag = base_pos + 64'($urandom_range(0, 3));
                    send_varint((mag << 1) | 64'd1, 1'b0);
                end
                else
                begin
                    mag = POS_MAX - base_pos + 64'd1 + 64'($urandom_range(0, 3));
                    send_varint(mag << 1, 1'b0);
                end
            end
            FAULT_VARINT:
                repeat (bdp_pkg::VARINT_MAX_BYTES + 4'd1)
                    drive(bdp_pkg::CMD_PATCH,
                          8'($urandom_range(0, 255)) | bdp_pkg::VARINT_CONT,
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            FAULT_EARLY_PATCH:
            begin
                send_varint(64'd1, 1'b0);
                repeat (2)
                    drive(bdp_pkg::CMD_PATCH, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            FAULT_STRAY_BASE:
                drive(bdp_pkg::CMD_BASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            default:
            begin
                send_varint(64'd1, 1'b0);
                drive(bdp_pkg::CMD_PATCH, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                drive(bdp_pkg::CMD_BASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'b0);
            end
        endcase
    endtask

    // result side: random stall before each item
    initial
    begin : sink
        int unsigned stall;
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : watch
        bdp_pkg::result_t got;
        bdp_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind         = m_axis_tuser;
            got.out_byte     = m_axis_tdata[7:0];
            got.base_address = m_axis_tdata[39:8];
            got.status_ok    = m_axis_tdata[40];
            got.err_code     = m_axis_tdata[43:41];
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected result kind %0d byte %02h addr %08h ok %0d code %0d",
                         $time, got.kind, got.out_byte, got.base_address, got.status_ok,
                         got.err_code);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                begin
                    fails++;
                    $display("%0t: expected kind %0d byte %02h addr %08h ok %0d code %0d",
                             $time, want.kind, want.out_byte, want.base_address,
                             want.status_ok, want.err_code);
                    $display("%0t:      got kind %0d byte %02h addr %08h ok %0d code %0d",
                             $time, got.kind, got.out_byte, got.base_address,
                             got.status_ok, got.err_code);
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned k;
        int unsigned bad_row;
        logic [7:0]  flip;
        row_t        row;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        fault   = ($urandom_range(0, 7) == 0) ? FAULT_HEADER : fault_t'($urandom_range(0, 4));
        bad_row = $urandom_range(HDR_ROW0, HDR_ROW0 + 7);
        flip    = 8'($urandom_range(1, 255));

        // directed table, with one header byte spoiled in a bad-header run
        for (k = 0; k < N_ROWS; k++)
        begin
            row = DIRECTED[k];
            if (fault == FAULT_HEADER)
            begin
                row.chk = CHK_MODEL;
                if (k == bad_row)
                    row.pb = row.pb ^ flip;
            end
            drive(row.cmd, row.pb, row.bb, row.bv, row.chk, row.res);
        end

        if (fault == FAULT_HEADER)
        begin
            while (items_in < ITEMS)
                drive_noise();
        end
        else
        begin
            while (items_in < ITEMS)
            begin
                if ($urandom_range(0, 19) == 0)
                    calm = !calm;
                send_record();
            end
            calm = 1'b0;
            inject_fault();
            // after the error only end queries answer
            repeat (40) drive_noise();
        end
        s_axis_tvalid <= 1'b0;

        // drain
        for (k = 0; k < DRAIN_LIMIT && awaited_results.size() != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            fails += awaited_results.size();
            $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
        end

        $display("covered %0d items in and %0d results out through header, add, copy and seek",
                 items_in, results_seen);
        $display("closing error case: %s", fault.name());
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard
    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
